[src/csb_pkg.sv]
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types and constants of the cross stencil filter.
// ----------------------------------------------------------------------------
package csb_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int PIXEL_BITS_DEF = 16;

  localparam int VALUE_W = 19;
  localparam int ROW_W   = 16;
  localparam int COL_W   = 11;
  localparam int CFG_W   = 16;
  localparam int COLS_W  = 12;

  localparam logic [ROW_W-1:0]  ROWS_RST = 16'd1024;
  localparam logic [COLS_W-1:0] COLS_RST = 12'd1536;

  localparam logic CFG_FRAME_ROWS = 1'b0;
  localparam logic CFG_FRAME_COLS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_CALC,
    ST_EVAL,
    ST_SQ1,
    ST_OUT1,
    ST_SQ2,
    ST_OUT2
  } state_t;

  typedef enum logic {
    SQ_ABOVE,
    SQ_PIXEL
  } sq_src_t;

  typedef enum logic {
    OUT_SUM,
    OUT_SQRT
  } out_sel_t;

  typedef struct packed {
    logic     accept;
    logic     rd_second;
    logic     cap_first;
    logic     cap_second;
    logic     sq_start;
    sq_src_t  sq_src;
    logic     load_out;
    out_sel_t out_sel;
    logic     out_res2;
  } cmd_t;

  typedef struct packed {
    logic has1;
    logic border1;
    logic last_row;
    logic sq_done;
  } status_t;

endpackage

[src/csb_ram.sv]
// ----------------------------------------------------------------------------
// csb_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module csb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/csb_sqrt.sv]
// ----------------------------------------------------------------------------
// csb_sqrt
// Iterative integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module csb_sqrt #(
  parameter int XW = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [XW-1:0]           x,
  output logic                    done,
  output logic [(XW+1)/2-1:0]     root
);

  localparam int RW  = (XW + 1) / 2;
  localparam int XE  = 2 * RW;
  localparam int RMW = RW + 2;
  localparam int CNW = $clog2(RW + 1);

  logic [XE-1:0]  x_r, x_nxt;
  logic [RMW-1:0] rem_r, rem_nxt;
  logic [RW-1:0]  root_r, root_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;

  logic [RMW-1:0] rem_sh;
  logic [RMW-1:0] trial;

  always_comb begin
    rem_sh   = {rem_r[RMW-3:0], x_r[XE-1:XE-2]};
    trial    = {root_r, 2'b01};
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = XE'(x);
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNW'(RW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt = {x_r[XE-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[RW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[src/csb_ctrl.sv]
// ----------------------------------------------------------------------------
// csb_ctrl
// Sequencer: line store reads, write back, square root and result delivery.
// ----------------------------------------------------------------------------
module csb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  csb_pkg::status_t sts,
  output csb_pkg::cmd_t    cmd
);

  csb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      csb_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = csb_pkg::ST_RD1;
        end
      end
      csb_pkg::ST_RD1: begin
        state_nxt = csb_pkg::ST_RD2;
      end
      csb_pkg::ST_RD2: begin
        cmd.rd_second = 1'b1;
        cmd.cap_first = 1'b1;
        state_nxt     = csb_pkg::ST_CALC;
      end
      csb_pkg::ST_CALC: begin
        cmd.cap_second = 1'b1;
        state_nxt      = csb_pkg::ST_EVAL;
      end
      csb_pkg::ST_EVAL: begin
        priority if (sts.has1 && sts.border1) begin
          cmd.sq_start = 1'b1;
          cmd.sq_src   = csb_pkg::SQ_ABOVE;
          state_nxt    = csb_pkg::ST_SQ1;
        end else if (sts.has1) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = csb_pkg::OUT_SUM;
          state_nxt    = csb_pkg::ST_OUT1;
        end else if (sts.last_row) begin
          cmd.sq_start = 1'b1;
          cmd.sq_src   = csb_pkg::SQ_PIXEL;
          state_nxt    = csb_pkg::ST_SQ2;
        end else begin
          state_nxt = csb_pkg::ST_IDLE;
        end
      end
      csb_pkg::ST_SQ1: begin
        if (sts.sq_done) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = csb_pkg::OUT_SQRT;
          state_nxt    = csb_pkg::ST_OUT1;
        end
      end
      csb_pkg::ST_OUT1: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (sts.last_row) begin
            cmd.sq_start = 1'b1;
            cmd.sq_src   = csb_pkg::SQ_PIXEL;
            state_nxt    = csb_pkg::ST_SQ2;
          end else begin
            state_nxt = csb_pkg::ST_IDLE;
          end
        end
      end
      csb_pkg::ST_SQ2: begin
        if (sts.sq_done) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = csb_pkg::OUT_SQRT;
          cmd.out_res2 = 1'b1;
          state_nxt    = csb_pkg::ST_OUT2;
        end
      end
      csb_pkg::ST_OUT2: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = csb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = csb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[src/csb_datapath.sv]
// ----------------------------------------------------------------------------
// csb_datapath
// Counters, frame registers, line stores, cross sum and result register.
// ----------------------------------------------------------------------------
module csb_datapath #(
  parameter int MAX_WIDTH  = csb_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = csb_pkg::PIXEL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [csb_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic [PIXEL_BITS-1:0]       pixel,
  input  csb_pkg::cmd_t               cmd,
  output csb_pkg::status_t            sts,
  output logic [csb_pkg::VALUE_W-1:0] out_value,
  output logic [csb_pkg::ROW_W-1:0]   out_row,
  output logic [csb_pkg::COL_W-1:0]   out_col,
  output logic                        out_border,
  output logic                        out_done,
  output logic                        out_last
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CNW  = $clog2(MAX_WIDTH + 1);
  localparam int KW   = ((CNW > csb_pkg::COLS_W) ? CNW : csb_pkg::COLS_W) + 1;
  localparam int SUMW = PIXEL_BITS + 3;
  localparam int XW   = PIXEL_BITS + 8;
  localparam int RW   = (XW + 1) / 2;
  localparam int RWD  = csb_pkg::ROW_W;

  logic [RWD-1:0]                 rows_cfg_r;
  logic [csb_pkg::COLS_W-1:0]     cols_cfg_r;
  logic [RWD-1:0]                 row_r;
  logic [CNW-1:0]                 col_r;

  logic [PIXEL_BITS-1:0] p_r, a0_r, t0_r, a1_r, t1_r;
  logic [CW-1:0]         c_r;
  logic [RWD-1:0]        r_r;
  logic                  has1_r, border1_r, last_row_r, last_col_r;

  logic [RWD-1:0]  rows_eff, orow;
  logic [KW-1:0]   cols_eff;
  logic [CW-1:0]   c_cl;
  logic            last_row, last_col, border1;

  logic [CW-1:0]         a_raddr, t_raddr;
  logic [PIXEL_BITS-1:0] a_rdata, t_rdata;

  logic          sq_done;
  logic [RW-1:0] sq_root;
  logic [XW-1:0] sq_x;
  logic [SUMW-1:0] sum;

  logic [csb_pkg::VALUE_W-1:0] val_r;
  logic [RWD-1:0]              orow_r;
  logic [csb_pkg::COL_W-1:0]   ocol_r;
  logic                        obord_r, odone_r, olast_r;

  always_comb begin
    rows_eff = (rows_cfg_r == '0) ? RWD'(1) : rows_cfg_r;
    cols_eff = KW'(cols_cfg_r);
    if (cols_eff == '0) begin
      cols_eff = KW'(1);
    end else if (cols_eff > KW'(MAX_WIDTH)) begin
      cols_eff = KW'(MAX_WIDTH);
    end
    c_cl     = (KW'(col_r) >= KW'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) : CW'(col_r);
    last_row = row_r >= rows_eff - 1'b1;
    last_col = KW'(c_cl) >= cols_eff - 1'b1;
    orow     = row_r - 1'b1;
    border1  = (orow == '0) || (orow >= rows_eff - 1'b1) || (c_cl == '0) || last_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= csb_pkg::ROWS_RST;
      cols_cfg_r <= csb_pkg::COLS_RST;
      row_r      <= '0;
      col_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          csb_pkg::CFG_FRAME_ROWS: rows_cfg_r <= cfg_wdata;
          csb_pkg::CFG_FRAME_COLS: cols_cfg_r <= cfg_wdata[csb_pkg::COLS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + 1'b1;
        end else begin
          col_r <= CNW'(c_cl) + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_r        <= pixel;
      c_r        <= c_cl;
      r_r        <= row_r;
      has1_r     <= row_r != '0;
      border1_r  <= border1;
      last_row_r <= last_row;
      last_col_r <= last_col;
    end
    if (cmd.cap_first) begin
      a0_r <= a_rdata;
      t0_r <= t_rdata;
    end
    if (cmd.cap_second) begin
      a1_r <= a_rdata;
      t1_r <= t_rdata;
    end
  end

  assign a_raddr = cmd.rd_second ? c_r + 1'b1 : c_r;
  assign t_raddr = cmd.rd_second ? c_r - 1'b1 : c_r;

  csb_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (cmd.cap_second),
    .waddr (c_r),
    .wdata (p_r),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  csb_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_two_above (
    .clk   (clk),
    .we    (cmd.cap_second),
    .waddr (c_r),
    .wdata (a0_r),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  assign sq_x = (cmd.sq_src == csb_pkg::SQ_ABOVE) ? {a0_r, 8'd0} : {p_r, 8'd0};

  csb_sqrt #(.XW(XW)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign sum = SUMW'(p_r) + SUMW'(a0_r) + SUMW'(t0_r) + SUMW'(a1_r) + SUMW'(t1_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      val_r  <= (cmd.out_sel == csb_pkg::OUT_SUM) ? csb_pkg::VALUE_W'(sum)
                                                  : csb_pkg::VALUE_W'(sq_root);
      ocol_r <= csb_pkg::COL_W'(c_r);
      if (cmd.out_res2) begin
        orow_r  <= r_r;
        obord_r <= 1'b1;
        odone_r <= last_col_r;
        olast_r <= 1'b1;
      end else begin
        orow_r  <= r_r - 1'b1;
        obord_r <= border1_r;
        odone_r <= 1'b0;
        olast_r <= !last_row_r;
      end
    end
  end

  assign sts.has1     = has1_r;
  assign sts.border1  = border1_r;
  assign sts.last_row = last_row_r;
  assign sts.sq_done  = sq_done;

  assign out_value  = val_r;
  assign out_row    = orow_r;
  assign out_col    = ocol_r;
  assign out_border = obord_r;
  assign out_done   = odone_r;
  assign out_last   = olast_r;

endmodule

[src/cross_stencil_sum_border_sqrt_unit.sv]
// ----------------------------------------------------------------------------
// cross_stencil_sum_border_sqrt_unit
// Five-point cross stencil over a raster frame, square root on the border.
// ----------------------------------------------------------------------------
// One pixel at a time: a new pixel is accepted only once the previous one is
// finished. The pace is set by the two-pass line store read and by the bit-serial
// square root that border results need; output stalls add to that.
// Reset: counters cleared, frame_rows 1024, frame_cols 1536; line stores kept.
module cross_stencil_sum_border_sqrt_unit #(
  parameter int MAX_WIDTH  = csb_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = csb_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [csb_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]   in_tdata,   // pixel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [47:0]                       out_tdata,  // value, out_row, out_col
  output logic [1:0]                        out_tuser,  // is_border, frame_done
  output logic                              out_tlast
);

  csb_pkg::cmd_t    cmd;
  csb_pkg::status_t sts;

  logic [csb_pkg::VALUE_W-1:0] value;
  logic [csb_pkg::ROW_W-1:0]   row;
  logic [csb_pkg::COL_W-1:0]   col;
  logic                        border, done;

  csb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  csb_datapath #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .pixel      (in_tdata[PIXEL_BITS-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_value  (value),
    .out_row    (row),
    .out_col    (col),
    .out_border (border),
    .out_done   (done),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, col, row, value};
  assign out_tuser = {done, border};

endmodule
